// File: design/plist_pkg.sv
// plist_pkg: shared types and constants for the positional list block
// no dependencies; imported by plist_mem, plist_seq and the top level
`timescale 1ns / 1ps
`default_nettype none

package plist_pkg;

    localparam int OP_W  = 3;
    localparam int POS_W = 7;
    localparam int VAL_W = 16;
    localparam int ST_W  = 2;
    localparam int CNT_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_SEARCH = 3'd2,
        OP_INSERT = 3'd3,
        OP_DELETE = 3'd4,
        OP_READ   = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_BADPOS   = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_SEARCH,
        S_FIN
    } state_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

`default_nettype wire

// File: design/plist_mem.sv
// plist_mem: entry store, one write port and one registered read port
// depends on plist_pkg
`timescale 1ns / 1ps
`default_nettype none

module plist_mem
    import plist_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic             aclk,
    input  wire mem_ctl_t         ctl,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [VAL_W-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [VAL_W-1:0] rdata
);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (ctl.re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/plist_seq.sv
// plist_seq: sequencer, count, shift/search walk and result register
// depends on plist_pkg; drives the plist_mem ports
`timescale 1ns / 1ps
`default_nettype none

module plist_seq
    import plist_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [OP_W-1:0]  s_op,
    input  wire logic [POS_W-1:0] s_position,
    input  wire logic [VAL_W-1:0] s_value,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic      [ST_W-1:0]  m_status,
    output logic      [POS_W-1:0] m_match_position,
    output logic      [VAL_W-1:0] m_read_value,
    output logic      [CNT_W-1:0] m_entry_count,
    output logic                  m_last,
    output mem_ctl_t              mem_ctl,
    output logic      [AW-1:0]    mem_waddr,
    output logic      [VAL_W-1:0] mem_wdata,
    output logic      [AW-1:0]    mem_raddr,
    input  wire logic [VAL_W-1:0] mem_rdata
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    logic               hold_vld_reg, hold_vld_next;
    logic [CNT_W-1:0]   hold_pos_reg, hold_pos_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic [AW-1:0]      ins_addr_reg, ins_addr_next;
    status_t            fin_status_reg, fin_status_next;
    logic [POS_W-1:0]   fin_match_reg, fin_match_next;
    logic               fin_rd_reg, fin_rd_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [POS_W-1:0]   out_match_reg, out_match_next;
    logic [VAL_W-1:0]   out_rdval_reg, out_rdval_next;
    logic [CNT_W-1:0]   out_count_reg, out_count_next;
    logic               out_last_reg, out_last_next;

    logic               accept;
    logic               out_free;
    logic               pos_bad;
    logic               is_full;
    logic [POS_W-1:0]   pos_m1;
    logic               hit;
    logic               blocked;
    logic               issue;
    logic [CNT_W-1:0]   pend_pos;

    assign accept   = s_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_ready;
    assign pos_bad  = (s_position == '0) || (s_position > count_reg);
    assign is_full  = (count_reg >= DEPTH_C);
    assign pos_m1   = s_position - POS_W'(1);
    assign pend_pos = CNT_W'(pend_addr_reg) + CNT_W'(1);

    // search walk
    assign hit     = pend_reg && (mem_rdata == val_reg);
    assign blocked = hit && hold_vld_reg && !out_free;
    assign issue   = (idx_reg < count_reg) && (!pend_reg || !blocked);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (op_t'(s_op))
                        OP_SEARCH: state_next = S_SEARCH;
                        OP_INSERT: begin
                            state_next = (is_full || pos_bad) ? S_FIN : S_SHIFT_UP;
                        end
                        OP_DELETE: state_next = pos_bad ? S_FIN : S_SHIFT_DN;
                        default:   state_next = S_FIN;
                    endcase
                end
            end
            S_SHIFT_UP, S_SHIFT_DN: begin
                if (rem_reg == '0 && !pend_reg) begin
                    state_next = S_FIN;
                end
            end
            S_SEARCH: begin
                if (!pend_reg && !(idx_reg < count_reg)) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        hold_vld_next   = hold_vld_reg;
        hold_pos_next   = hold_pos_reg;
        val_next        = val_reg;
        ins_addr_next   = ins_addr_reg;
        fin_status_next = fin_status_reg;
        fin_match_next  = fin_match_reg;
        fin_rd_next     = fin_rd_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_match_next  = out_match_reg;
        out_rdval_next  = out_rdval_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        mem_ctl         = '0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    fin_status_next = STAT_OK;
                    fin_match_next  = '0;
                    fin_rd_next     = 1'b0;
                    val_next        = s_value;
                    case (op_t'(s_op))
                        OP_CLEAR: count_next = '0;
                        OP_APPEND: begin
                            if (is_full) begin
                                fin_status_next = STAT_FULL;
                            end else begin
                                mem_ctl.we = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = s_value;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_SEARCH: begin
                            idx_next      = '0;
                            pend_next     = 1'b0;
                            hold_vld_next = 1'b0;
                        end
                        OP_INSERT: begin
                            if (is_full) begin
                                fin_status_next = STAT_FULL;
                            end else if (pos_bad) begin
                                fin_status_next = STAT_BADPOS;
                            end else begin
                                idx_next      = count_reg - CNT_W'(1);
                                rem_next      = count_reg - s_position + CNT_W'(1);
                                ins_addr_next = pos_m1[AW-1:0];
                                pend_next     = 1'b0;
                            end
                        end
                        OP_DELETE: begin
                            if (pos_bad) begin
                                fin_status_next = STAT_BADPOS;
                            end else begin
                                idx_next  = s_position;
                                rem_next  = count_reg - s_position;
                                pend_next = 1'b0;
                            end
                        end
                        OP_READ: begin
                            if (pos_bad) begin
                                fin_status_next = STAT_BADPOS;
                            end else begin
                                mem_ctl.re     = 1'b1;
                                mem_raddr      = pos_m1[AW-1:0];
                                fin_rd_next    = 1'b1;
                                fin_match_next = s_position;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SHIFT_UP, S_SHIFT_DN: begin
                if (pend_reg) begin
                    mem_ctl.we = 1'b1;
                    mem_waddr  = (state_reg == S_SHIFT_UP) ? pend_addr_reg + AW'(1)
                                                           : pend_addr_reg - AW'(1);
                    mem_wdata  = mem_rdata;
                end
                if (rem_reg != '0) begin
                    mem_ctl.re     = 1'b1;
                    mem_raddr      = idx_reg[AW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[AW-1:0];
                    idx_next       = (state_reg == S_SHIFT_UP) ? idx_reg - CNT_W'(1)
                                                               : idx_reg + CNT_W'(1);
                    rem_next       = rem_reg - CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                end
                if (rem_reg == '0 && !pend_reg) begin
                    fin_status_next = STAT_OK;
                    if (state_reg == S_SHIFT_UP) begin
                        mem_ctl.we = 1'b1;
                        mem_waddr  = ins_addr_reg;
                        mem_wdata  = val_reg;
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            S_SEARCH: begin
                if (pend_reg && !blocked) begin
                    if (hit) begin
                        // earlier match goes out now that another one follows
                        if (hold_vld_reg) begin
                            out_valid_next  = 1'b1;
                            out_status_next = STAT_OK;
                            out_match_next  = hold_pos_reg;
                            out_rdval_next  = '0;
                            out_count_next  = count_reg;
                            out_last_next   = 1'b0;
                        end
                        hold_vld_next = 1'b1;
                        hold_pos_next = pend_pos;
                    end
                end
                if (issue) begin
                    mem_ctl.re     = 1'b1;
                    mem_raddr      = idx_reg[AW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[AW-1:0];
                    idx_next       = idx_reg + CNT_W'(1);
                end else if (pend_reg && !blocked) begin
                    pend_next = 1'b0;
                end
                if (!pend_reg && !(idx_reg < count_reg)) begin
                    fin_rd_next = 1'b0;
                    if (hold_vld_reg) begin
                        fin_status_next = STAT_OK;
                        fin_match_next  = hold_pos_reg;
                    end else begin
                        fin_status_next = STAT_NOTFOUND;
                        fin_match_next  = '0;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = fin_status_reg;
                    out_match_next  = fin_match_reg;
                    out_rdval_next  = fin_rd_reg ? mem_rdata : '0;
                    out_count_next  = count_reg;
                    out_last_next   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            hold_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            hold_vld_reg  <= hold_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        rem_reg        <= rem_next;
        pend_addr_reg  <= pend_addr_next;
        hold_pos_reg   <= hold_pos_next;
        val_reg        <= val_next;
        ins_addr_reg   <= ins_addr_next;
        fin_status_reg <= fin_status_next;
        fin_match_reg  <= fin_match_next;
        fin_rd_reg     <= fin_rd_next;
        out_status_reg <= out_status_next;
        out_match_reg  <= out_match_next;
        out_rdval_reg  <= out_rdval_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_match_position = out_match_reg;
    assign m_read_value     = out_rdval_reg;
    assign m_entry_count    = out_count_reg;
    assign m_last           = out_last_reg;

endmodule

`default_nettype wire

// File: design/positional_list_search_insert_delete.sv
// positional_list_search_insert_delete: top level of the positional grade list
// depends on plist_pkg, plist_mem, plist_seq
//
//   channel  handshake         payload
//   s_       s_valid/s_ready   s_op, s_position, s_value
//   m_       m_valid/m_ready   m_status, m_match_position, m_read_value,
//                              m_entry_count, m_last
//
// clear, append, read and rejected ops need no walk; insert shifts the entries from
// the position up, delete shifts those after it down and search walks every entry,
// each walking one entry a cycle through the memory; a full result register adds stalls.
// synchronous active-low reset empties the list; entries keep no reset value.
// a result waits in the output register while the next beat is accepted; search
// pauses its walk only when a second match finds it full.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_search_insert_delete
    import plist_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [OP_W-1:0]  s_op,
    input  wire logic [POS_W-1:0] s_position,
    input  wire logic [VAL_W-1:0] s_value,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic      [ST_W-1:0]  m_status,
    output logic      [POS_W-1:0] m_match_position,
    output logic      [VAL_W-1:0] m_read_value,
    output logic      [CNT_W-1:0] m_entry_count,
    output logic                  m_last
);

    localparam int AW = $clog2(DEPTH);

    mem_ctl_t         mem_ctl;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;

    plist_seq #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_position       (s_position),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_match_position (m_match_position),
        .m_read_value     (m_read_value),
        .m_entry_count    (m_entry_count),
        .m_last           (m_last),
        .mem_ctl          (mem_ctl),
        .mem_waddr        (mem_waddr),
        .mem_wdata        (mem_wdata),
        .mem_raddr        (mem_raddr),
        .mem_rdata        (mem_rdata)
    );

    plist_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire
